@@ hdl/kbsi_pkg.sv @@
// Shared types and constants for the k-best sorted insert list.
// No dependencies; the cell, chain and top-level files import this package.
package kbsi_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int KIDX_W     = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KEEP_W     = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd8;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_CLEAR   = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [31:0] distance;
    logic [15:0] tag;
    logic [7:0]  cls;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  held_count;
    logic [31:0] worst_distance;
    logic        entry_valid;
    logic [3:0]  entry_rank;
    logic [15:0] entry_tag;
    logic [7:0]  entry_class;
    logic [31:0] entry_distance;
    logic        last;
  } out_item_t;

endpackage

@@ hdl/kbsi_channels.sv @@
// Valid/ready channel interfaces of the k-best sorted insert list:
// request input, result output and keep-count configuration write.
// Fixed field widths, no package dependency.
interface kbsi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] cand_distance;
  logic [15:0] cand_tag;
  logic [7:0]  cand_class;

  modport source (output valid, req_type, cand_distance, cand_tag, cand_class,
                  input ready);
  modport sink   (input valid, req_type, cand_distance, cand_tag, cand_class,
                  output ready);
endinterface

interface kbsi_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  held_count;
  logic [31:0] worst_distance;
  logic        entry_valid;
  logic [3:0]  entry_rank;
  logic [15:0] entry_tag;
  logic [7:0]  entry_class;
  logic [31:0] entry_distance;
  logic        last;

  modport source (output valid, accepted, held_count, worst_distance, entry_valid,
                  entry_rank, entry_tag, entry_class, entry_distance, last,
                  input ready);
  modport sink   (input valid, accepted, held_count, worst_distance, entry_valid,
                  entry_rank, entry_tag, entry_class, entry_distance, last,
                  output ready);
endinterface

interface kbsi_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/kbsi_cell.sv @@
// One compare-and-shift cell of the sorted list: holds one entry.
// Depends on kbsi_pkg for the entry type.
module kbsi_cell (
  input  logic            clk,
  input  logic            we,
  input  logic            beyond,
  input  kbsi_pkg::entry_t cand,
  input  logic            left_flag,
  input  kbsi_pkg::entry_t left,
  output logic            flag,
  output kbsi_pkg::entry_t slot
);
  import kbsi_pkg::*;

  entry_t slot_r;
  entry_t slot_nxt;

  // Set when the candidate goes at or ahead of this cell.
  assign flag = beyond || (slot_r.distance > cand.distance);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (left_flag) begin
      slot_nxt = left;
    end else if (flag) begin
      slot_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

@@ hdl/kbsi_chain.sv @@
// Row of compare-and-shift cells forming the sorted list.
// Depends on kbsi_pkg and kbsi_cell.
module kbsi_chain (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [kbsi_pkg::CNT_W-1:0]           n_eff,
  input  kbsi_pkg::entry_t                     cand,
  output logic [kbsi_pkg::MAX_KEEP-1:0]        flags,
  output kbsi_pkg::entry_t [kbsi_pkg::MAX_KEEP-1:0] slots
);
  import kbsi_pkg::*;

  genvar i;
  generate
    for (i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic   beyond;
      logic   left_flag;
      entry_t left;

      // Slots at or past the fill level count as larger than any candidate.
      assign beyond = (CNT_W'(i) >= n_eff);

      if (i == 0) begin : g_head
        assign left_flag = 1'b0;
        assign left      = cand;
      end else begin : g_link
        assign left_flag = flags[i-1];
        assign left      = slots[i-1];
      end

      kbsi_cell u_cell (
        .clk       (clk),
        .we        (we),
        .beyond    (beyond),
        .cand      (cand),
        .left_flag (left_flag),
        .left      (left),
        .flag      (flags[i]),
        .slot      (slots[i])
      );
    end
  endgenerate

endmodule

@@ hdl/k_best_sorted_insert.sv @@
// k-best sorted insert list: top level with control and result register.
// Depends on kbsi_pkg, kbsi_channels and kbsi_chain.
//
// Usage: requests arrive on in_ch (insert, clear, read out). Each insert is
// compared against every held entry at once by the cell row and, if taken,
// lands in the same cycle it is accepted. One status transaction follows on
// out_ch for insert, clear and unknown requests; a read out gives one
// transaction per held entry, nearest first, with last on the final one,
// or one status transaction when the list is empty.
// An accepted request moves the sequencer from idle to a status or read state,
// which loads the output register once it is free. A read out passes one entry
// per cycle from the cell row while the receiver does not stall.
// A new request is taken as soon as the previous one has loaded its last
// result, even while that result still waits on out_ch.ready.
// A stalled receiver holds the output register and freezes the sequencer.
// cfg_ch writes keep_count at any time and is always ready; write it only
// while the block is idle. Reset empties the list and sets keep_count to 8.
module k_best_sorted_insert (
  input  logic clk,
  input  logic rst_n,
  kbsi_in_if.sink    in_ch,
  kbsi_out_if.source out_ch,
  kbsi_cfg_if.sink   cfg_ch
);
  import kbsi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STAT = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [KEEP_W-1:0] keep_count_r;
  logic [CNT_W-1:0]  fill_count_r, fill_count_nxt;
  logic              acc_r, acc_nxt;
  logic [KIDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [CNT_W-1:0]  k_eff;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  rd_n;
  logic              in_fire;
  logic              ins_ok;
  logic              cell_we;
  logic              out_free;
  logic              rd_last;
  logic [KIDX_W-1:0] worst_idx;
  logic [31:0]       worst_dist;
  entry_t            cand;
  entry_t            rd_entry;

  logic [MAX_KEEP-1:0]         flags;
  entry_t [MAX_KEEP-1:0]       slots;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
    end else if (cfg_ch.valid) begin
      keep_count_r <= cfg_ch.data;
    end
  end

  assign k_eff = (32'(keep_count_r) > 32'(MAX_KEEP)) ? CNT_W'(MAX_KEEP)
                                                     : CNT_W'(keep_count_r);
  assign n_eff = (fill_count_r > k_eff) ? k_eff : fill_count_r;

  assign cand.distance = in_ch.cand_distance;
  assign cand.tag      = in_ch.cand_tag;
  assign cand.cls      = in_ch.cand_class;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Taken when the insert position falls inside the first k slots.
  assign ins_ok  = (k_eff != '0) && flags[KIDX_W'(k_eff - CNT_W'(1))];
  assign cell_we = in_fire && (in_ch.req_type == REQ_INSERT) && ins_ok;

  kbsi_chain u_chain (
    .clk   (clk),
    .we    (cell_we),
    .n_eff (n_eff),
    .cand  (cand),
    .flags (flags),
    .slots (slots)
  );

  assign worst_idx  = KIDX_W'(fill_count_r - CNT_W'(1));
  assign worst_dist = (fill_count_r != '0) ? slots[worst_idx].distance : 32'd0;
  assign rd_n       = (32'(fill_count_r) > 32'(RESULT_CAP)) ? CNT_W'(RESULT_CAP)
                                                            : fill_count_r;
  assign rd_last    = ((32'(rd_idx_r) + 32'd1) == 32'(rd_n));
  assign rd_entry   = slots[rd_idx_r];
  assign out_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    acc_nxt        = acc_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_nxt        = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          fill_count_nxt = n_eff;
          acc_nxt        = 1'b0;
          rd_idx_nxt     = '0;
          state_nxt      = ST_STAT;
          case (in_ch.req_type)
            REQ_INSERT: begin
              acc_nxt = ins_ok;
              if (ins_ok && (n_eff < k_eff)) begin
                fill_count_nxt = n_eff + CNT_W'(1);
              end
            end
            REQ_CLEAR: begin
              fill_count_nxt = '0;
            end
            REQ_READ: begin
              if (n_eff != '0) begin
                state_nxt = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt                = '0;
          out_nxt.accepted       = acc_r;
          out_nxt.held_count     = 5'(fill_count_r);
          out_nxt.worst_distance = worst_dist;
          out_nxt.last           = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.accepted       = 1'b0;
          out_nxt.held_count     = 5'(fill_count_r);
          out_nxt.worst_distance = worst_dist;
          out_nxt.entry_valid    = 1'b1;
          out_nxt.entry_rank     = 4'(rd_idx_r);
          out_nxt.entry_tag      = rd_entry.tag;
          out_nxt.entry_class    = rd_entry.cls;
          out_nxt.entry_distance = rd_entry.distance;
          out_nxt.last           = rd_last;
          rd_idx_nxt             = rd_idx_r + KIDX_W'(1);
          if (rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      acc_r        <= 1'b0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      acc_r        <= acc_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = out_r.accepted;
  assign out_ch.held_count     = out_r.held_count;
  assign out_ch.worst_distance = out_r.worst_distance;
  assign out_ch.entry_valid    = out_r.entry_valid;
  assign out_ch.entry_rank     = out_r.entry_rank;
  assign out_ch.entry_tag      = out_r.entry_tag;
  assign out_ch.entry_class    = out_r.entry_class;
  assign out_ch.entry_distance = out_r.entry_distance;
  assign out_ch.last           = out_r.last;

`ifndef NO_ASSERTIONS
  // The sequencer must leave idle for every accepted request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request accepted without leaving idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_count_r) <= 32'(MAX_KEEP))
    else $error("fill count above list depth");

  // Sorted cells give a single run of set flags from the insert position up.
  a_flags_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(flags ^ (flags << 1)))
    else $error("cell row out of order");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.entry_valid) |-> out_ch.last)
    else $error("status transaction without last");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking bench for the k-best sorted insert list (k_best_sorted_insert).
// Depends on kbsi_pkg and the channel interfaces in kbsi_channels; a scoreboard
// class predicts every result transaction and plain tasks drive the channels.
module tb;
  import kbsi_pkg::*;

  class kbest_scoreboard;
    logic [31:0] held_dist [MAX_KEEP];
    logic [15:0] held_tag  [MAX_KEEP];
    logic [7:0]  held_cls  [MAX_KEEP];
    int unsigned fill = 0;
    int unsigned keep = KEEP_RESET;
    out_item_t   due_results [$];
    int unsigned errors = 0;
    int unsigned n_requests = 0;
    int unsigned n_taken = 0;
    int unsigned n_reads = 0;
    int unsigned n_results = 0;

    function void set_keep(logic [KEEP_W-1:0] value);
      keep = value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function out_item_t status_of(logic acc, logic lst);
      out_item_t res;
      res = '0;
      res.accepted       = acc;
      res.held_count     = fill[4:0];
      res.worst_distance = (fill != 0) ? held_dist[fill-1] : 32'd0;
      res.last           = lst;
      return res;
    endfunction

    // Work out the results caused by one accepted request and queue them.
    function void note_request(logic [1:0] req, logic [31:0] d, logic [15:0] t,
                               logic [7:0] c);
      int unsigned k, n, p, i, r;
      logic        taken;
      out_item_t   res;
      n_requests++;
      k = (keep > MAX_KEEP) ? MAX_KEEP : keep;
      // A lowered keep count trims the list before the request acts.
      if (fill > k) fill = k;
      case (req)
        REQ_INSERT: begin
          taken = 1'b0;
          n = fill;
          if (n < k || (n > 0 && d < held_dist[n-1])) begin
            p = 0;
            // Go in after every entry of equal distance.
            while (p < n && held_dist[p] <= d) p++;
            if (p < k) begin
              for (i = (n < k) ? n : k - 1; i > p; i--) begin
                held_dist[i] = held_dist[i-1];
                held_tag[i]  = held_tag[i-1];
                held_cls[i]  = held_cls[i-1];
              end
              held_dist[p] = d;
              held_tag[p]  = t;
              held_cls[p]  = c;
              if (n < k) fill = n + 1;
              taken = 1'b1;
              n_taken++;
            end
          end
          due_results.push_back(status_of(taken, 1'b1));
        end
        REQ_CLEAR: begin
          fill = 0;
          due_results.push_back(status_of(1'b0, 1'b1));
        end
        REQ_READ: begin
          n_reads++;
          n = (fill > RESULT_CAP) ? RESULT_CAP : fill;
          if (n == 0) begin
            due_results.push_back(status_of(1'b0, 1'b1));
          end else begin
            for (r = 0; r < n; r++) begin
              res = status_of(1'b0, r + 1 == n);
              res.entry_valid    = 1'b1;
              res.entry_rank     = r[3:0];
              res.entry_tag      = held_tag[r];
              res.entry_class    = held_cls[r];
              res.entry_distance = held_dist[r];
              due_results.push_back(res);
            end
          end
        end
        default: begin
          due_results.push_back(status_of(1'b0, 1'b1));
        end
      endcase
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (due_results.size() == 0) begin
        $error("result transaction with nothing expected: %p", got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      cmp("accepted", want.accepted, got.accepted);
      cmp("held_count", want.held_count, got.held_count);
      cmp("worst_distance", want.worst_distance, got.worst_distance);
      cmp("entry_valid", want.entry_valid, got.entry_valid);
      cmp("entry_rank", want.entry_rank, got.entry_rank);
      cmp("entry_tag", want.entry_tag, got.entry_tag);
      cmp("entry_class", want.entry_class, got.entry_class);
      cmp("entry_distance", want.entry_distance, got.entry_distance);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  kbsi_in_if  in_ch();
  kbsi_out_if out_ch();
  kbsi_cfg_if cfg_ch();

  k_best_sorted_insert i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  kbest_scoreboard sb = new;
  bit              steady_in;
  bit              hold_out;
  int unsigned     n_holds;
  int unsigned     n_keeps;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send(logic [1:0] req, logic [31:0] d, logic [15:0] t, logic [7:0] c);
    int gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= req;
    in_ch.cand_distance <= d;
    in_ch.cand_tag      <= t;
    in_ch.cand_class    <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(req, d, t, c);
  endtask

  task automatic send_random();
    logic [1:0]  req;
    logic [31:0] d;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 80)      req = REQ_INSERT;
    else if (r < 92) req = REQ_READ;
    else if (r < 95) req = REQ_CLEAR;
    else             req = REQ_UNKNOWN;
    case ($urandom_range(0, 5))
      0, 1: d = $urandom_range(0, 31);
      2: begin
        case ($urandom_range(0, 2))
          0: d = 32'h0000_0000;
          1: d = 32'hFFFF_FFFF;
          default: d = 32'hFFFF_FFFE;
        endcase
      end
      default: d = $urandom;
    endcase
    send(req, d, 16'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait for every expected result, then let the pipe go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(logic [KEEP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_keep(value);
    n_keeps++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, plus long holds on request from the stimulus.
  initial begin
    int        stall;
    bit        no_stall;
    out_item_t got;
    out_ch.ready <= 1'b0;
    no_stall = 1'b0;
    @(posedge clk);
    forever begin
      stall = no_stall ? 0 : pick_gap();
      if (hold_out) begin
        hold_out = 1'b0;
        n_holds++;
        stall = 120;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.accepted       = out_ch.accepted;
      got.held_count     = out_ch.held_count;
      got.worst_distance = out_ch.worst_distance;
      got.entry_valid    = out_ch.entry_valid;
      got.entry_rank     = out_ch.entry_rank;
      got.entry_tag      = out_ch.entry_tag;
      got.entry_class    = out_ch.entry_class;
      got.entry_distance = out_ch.entry_distance;
      got.last           = out_ch.last;
      sb.check_result(got);
      if ($urandom_range(0, 63) == 0) no_stall = !no_stall;
    end
  end

  initial begin
    logic [KEEP_W-1:0] keep_plan [9];
    int                ph, j;
    keep_plan = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd8};
    keep_plan[8] = 5'($urandom_range(0, 31));
    steady_in = 1'b0;
    hold_out  = 1'b0;
    n_holds   = 0;
    n_keeps   = 0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_INSERT;
    in_ch.cand_distance <= '0;
    in_ch.cand_tag      <= '0;
    in_ch.cand_class    <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset keep count of 8.
    send(REQ_READ, 32'd0, 16'd0, 8'd0);                  // read of an empty list
    send(REQ_UNKNOWN, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);   // unknown request
    send(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send(REQ_INSERT, 32'd0, 16'h0000, 8'h00);
    send(REQ_INSERT, 32'd100, 16'd1, 8'd1);
    send(REQ_INSERT, 32'd100, 16'd2, 8'd2);              // ties land after
    send(REQ_INSERT, 32'd100, 16'd3, 8'd3);
    send(REQ_INSERT, 32'd50, 16'd5, 8'd5);
    send(REQ_INSERT, 32'd200, 16'd6, 8'd6);
    send(REQ_INSERT, 32'h7FFF_FFFF, 16'h5555, 8'hAA);    // list now full
    send(REQ_INSERT, 32'hFFFF_FFFF, 16'd7, 8'd7);        // equal to worst: refused
    send(REQ_INSERT, 32'd100, 16'd4, 8'd4);              // worst falls off
    send(REQ_INSERT, 32'd0, 16'hAAAA, 8'h55);            // tie at the head
    send(REQ_READ, 32'd0, 16'd0, 8'd0);
    send(REQ_INSERT, 32'h8000_0000, 16'd8, 8'd8);        // above worst when full
    send(REQ_INSERT, 32'd1, 16'd9, 8'd9);
    send(REQ_READ, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send(REQ_UNKNOWN, 32'd0, 16'd0, 8'd0);
    send(REQ_CLEAR, 32'd0, 16'd0, 8'd0);
    send(REQ_READ, 32'd0, 16'd0, 8'd0);
    send(REQ_INSERT, 32'd5, 16'h1234, 8'h12);
    send(REQ_READ, 32'd0, 16'd0, 8'd0);
    settle();

    // Random part, one keep count per phase; the list carries over so a
    // lowered keep count trims a longer list.
    for (ph = 0; ph < 9; ph++) begin
      write_keep(keep_plan[ph]);
      steady_in = ($urandom_range(0, 3) == 0);
      for (j = 0; j < 47; j++) begin
        if (j == 10 && (ph == 1 || ph == 7)) hold_out = 1'b1;
        send_random();
      end
      settle();
    end

    $display("Ran %0d requests: %0d inserts taken, %0d read-outs, %0d results checked",
             sb.n_requests, sb.n_taken, sb.n_reads, sb.n_results);
    $display("Used %0d keep counts incl. 0 and 31; receiver held off %0d times",
             n_keeps, n_holds);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
